// ===== design/rrg_pkg.sv =====
package rrg_pkg;

  localparam int LANES      = 4;
  localparam int NUM_FIELDS = 4;
  localparam int FRAC_BITS  = 16;
  localparam int LOG_FRAC   = 30;

  // Quotient bits kept by the dividers; larger quotients saturate to all ones.
  localparam int QB    = 36;
  localparam int NUM_W = 35 + FRAC_BITS;
  localparam int DEN_W = 33;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IN_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE = 3'd5;

  localparam logic [30:0] GAMMA_ONE = 31'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] in_low;
    logic signed [31:0] in_high;
    logic [30:0]        gamma;
    logic signed [31:0] out_low;
    logic signed [31:0] out_high;
    logic               clamp_enable;
  } cfg_t;

  // Data that rides along a divider or a curve unit.
  typedef struct packed {
    logic signed [31:0] t;
    logic               neg;
  } sb_t;

  // Coefficient k of the exp2 product: c_0 = 2^32, c_k = isqrt(c_{k-1} * 2^31).
  function automatic logic [31:0] exp_coef(input int k);
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    c = 64'd1 << 32;
    for (int b = 1; b <= k; b++) begin
      x   = c << 31;
      res = '0;
      bv  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= res + bv) begin
          x   = x - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      c = res;
    end
    return c[31:0];
  endfunction

endpackage

// ===== design/rrg_if.sv =====
interface rrg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  modport source(output valid, value_a, value_b, value_c, value_d, input ready);
  modport sink(input valid, value_a, value_b, value_c, value_d, output ready);
endinterface

interface rrg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_a;
  logic signed [31:0] result_b;
  logic signed [31:0] result_c;
  logic signed [31:0] result_d;
  modport source(output valid, result_a, result_b, result_c, result_d, input ready);
  modport sink(input valid, result_a, result_b, result_c, result_d, output ready);
endinterface

// ===== design/rrg_div.sv =====
module rrg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rrg_pkg::NUM_W-1:0]  num,
  input  logic [rrg_pkg::DEN_W-1:0]  den,
  input  rrg_pkg::sb_t               in_sb,
  output logic                       out_valid,
  output logic [rrg_pkg::QB-1:0]     quo,
  output rrg_pkg::sb_t               out_sb
);
  import rrg_pkg::*;

  localparam int WIDE_W = DEN_W + QB;

  logic [QB:0]       vld;
  logic [QB:0]       ovf;
  logic [DEN_W-1:0]  rem [0:QB];
  logic [DEN_W-1:0]  dd  [0:QB];
  logic [QB-1:0]     nlo [0:QB];
  logic [QB-1:0]     q   [0:QB];
  sb_t               sb  [0:QB];
  logic [WIDE_W-1:0] num_x;

  assign num_x = WIDE_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      // A quotient that does not fit in QB bits is flagged here.
      ovf[0] <= num_x >= {den, {QB{1'b0}}};
      rem[0] <= DEN_W'(num[NUM_W-1:QB]);
      nlo[0] <= num[QB-1:0];
      q[0]   <= '0;
      dd[0]  <= den;
      sb[0]  <= in_sb;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[j-1], nlo[j-1][QB-j]};
    assign ge    = trial >= {1'b0, dd[j-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
      if (en) begin
        rem[j] <= ge ? DEN_W'(trial - {1'b0, dd[j-1]}) : trial[DEN_W-1:0];
        q[j]   <= {q[j-1][QB-2:0], ge};
        nlo[j] <= nlo[j-1];
        ovf[j] <= ovf[j-1];
        dd[j]  <= dd[j-1];
        sb[j]  <= sb[j-1];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo       = ovf[QB] ? {QB{1'b1}} : q[QB];
  assign out_sb    = sb[QB];

endmodule

// ===== design/rrg_log.sv =====
module rrg_log (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  rrg_pkg::sb_t                 in_sb,
  output logic                         out_valid,
  output logic [4:0]                   int_part,
  output logic [rrg_pkg::LOG_FRAC-1:0] frac_part,
  output rrg_pkg::sb_t                 out_sb
);
  import rrg_pkg::*;

  logic [4:0]  lead;
  logic        a_v;
  logic [4:0]  a_p;
  logic [31:0] a_t;
  sb_t         a_sb;

  logic [LOG_FRAC:0]  vld;
  logic [31:0]        m   [0:LOG_FRAC];
  logic [4:0]         p   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fr [0:LOG_FRAC];
  sb_t                sb  [0:LOG_FRAC];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_sb.t[i]) begin
        lead = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v    <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      a_v    <= in_valid;
      vld[0] <= a_v;
    end
    if (en) begin
      a_p   <= lead;
      a_t   <= in_sb.t;
      a_sb  <= in_sb;
      // Normalize so that the leading one sits at bit 31 (Q1.31 mantissa).
      m[0]  <= a_t << (5'd31 - a_p);
      p[0]  <= a_p;
      fr[0] <= '0;
      sb[0] <= a_sb;
    end
  end

  for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_sq
    logic [63:0] pr;
    logic [32:0] s;
    assign pr = m[j-1] * m[j-1];
    assign s  = pr[63:31];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
      if (en) begin
        m[j]  <= s[32] ? s[32:1] : s[31:0];
        fr[j] <= {fr[j-1][LOG_FRAC-2:0], s[32]};
        p[j]  <= p[j-1];
        sb[j] <= sb[j-1];
      end
    end
  end

  assign out_valid = vld[LOG_FRAC];
  assign int_part  = p[LOG_FRAC];
  assign frac_part = fr[LOG_FRAC];
  assign out_sb    = sb[LOG_FRAC];

endmodule

// ===== design/rrg_exp.sv =====
module rrg_exp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rrg_pkg::LOG_FRAC-1:0] frac,
  input  logic [5:0]                   shift,
  input  logic                         to_max,
  input  logic                         to_zero,
  input  rrg_pkg::sb_t                 in_sb,
  output logic                         out_valid,
  output logic signed [31:0]           result,
  output rrg_pkg::sb_t                 out_sb
);
  import rrg_pkg::*;

  logic [LOG_FRAC:0]   vld;
  logic [LOG_FRAC:0]   mx;
  logic [LOG_FRAC:0]   zr;
  logic [31:0]         acc [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] f   [0:LOG_FRAC];
  logic [5:0]          k   [0:LOG_FRAC];
  sb_t                 sb  [0:LOG_FRAC];

  logic [32:0]        rsum;
  logic [32:0]        rsh;
  logic               r_v;
  logic signed [31:0] r_out;
  sb_t                r_sb;

  assign vld[0] = in_valid;
  assign mx[0]  = to_max;
  assign zr[0]  = to_zero;
  assign acc[0] = 32'h8000_0000;
  assign f[0]   = frac;
  assign k[0]   = shift;
  assign sb[0]  = in_sb;

  for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_mul
    localparam logic [31:0] COEF = exp_coef(j);
    logic [63:0] pr;
    assign pr = acc[j-1] * COEF;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
      if (en) begin
        acc[j] <= f[j-1][LOG_FRAC-j] ? pr[62:31] : acc[j-1];
        f[j]   <= f[j-1];
        k[j]   <= k[j-1];
        mx[j]  <= mx[j-1];
        zr[j]  <= zr[j-1];
        sb[j]  <= sb[j-1];
      end
    end
  end

  // Round half up while scaling the Q1.31 mantissa down to the output format.
  assign rsum = {1'b0, acc[LOG_FRAC]} + (33'd1 << (k[LOG_FRAC] - 6'd1));
  assign rsh  = rsum >> k[LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= vld[LOG_FRAC];
    end
    if (en) begin
      r_sb <= sb[LOG_FRAC];
      if (mx[LOG_FRAC]) begin
        r_out <= 32'sh7FFF_FFFF;
      end else if (zr[LOG_FRAC]) begin
        r_out <= '0;
      end else if (rsh[32:31] != 2'b00) begin
        r_out <= 32'sh7FFF_FFFF;
      end else begin
        r_out <= $signed(rsh[31:0]);
      end
    end
  end

  assign out_valid = r_v;
  assign result    = r_out;
  assign out_sb    = r_sb;

endmodule

// ===== design/rrg_lane.sv =====
module rrg_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rrg_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic signed [31:0] value,
  output logic               out_valid,
  output logic signed [31:0] result
);
  import rrg_pkg::*;

  localparam int N_MAX  = 31 - FRAC_BITS;
  localparam int N_ZERO = 31 - FRAC_BITS - 40;
  localparam logic signed [35:0] LOG_OFS = 36'(FRAC_BITS) <<< LOG_FRAC;

  // Input stage: numerator and denominator magnitudes of the normalization.
  logic signed [32:0] dnum;
  logic signed [32:0] dden;
  logic [32:0]        nmag;
  logic [32:0]        dmag;
  logic               s0_v;
  logic [NUM_W-1:0]   s0_num;
  logic [DEN_W-1:0]   s0_den;
  logic               s0_neg;

  assign dnum = $signed({value[31], value}) - $signed({cfg.in_low[31], cfg.in_low});
  assign dden = $signed({cfg.in_high[31], cfg.in_high})
              - $signed({cfg.in_low[31], cfg.in_low});
  assign nmag = dnum[32] ? 33'(-dnum) : dnum;
  assign dmag = dden[32] ? 33'(-dden) : dden;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
    if (en) begin
      s0_num <= NUM_W'({nmag, {FRAC_BITS{1'b0}}});
      s0_den <= dmag;
      s0_neg <= dnum[32] ^ dden[32];
    end
  end

  logic          d1_v;
  logic [QB-1:0] d1_q;
  sb_t           d1_sb;

  rrg_div u_div_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_v),
    .num(s0_num), .den(s0_den), .in_sb('{t: '0, neg: s0_neg}),
    .out_valid(d1_v), .quo(d1_q), .out_sb(d1_sb)
  );

  // Signed, saturated normalized value t.
  logic               big1;
  logic               t1_v;
  logic signed [31:0] t1;

  assign big1 = |d1_q[QB-1:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (en) begin
      t1_v <= d1_v;
    end
    if (en) begin
      if (!d1_sb.neg) begin
        t1 <= big1 ? 32'sh7FFF_FFFF : $signed(d1_q[31:0]);
      end else begin
        t1 <= big1 ? 32'sh8000_0000 : -$signed(d1_q[31:0]);
      end
    end
  end

  logic                lg_v;
  logic [4:0]          lg_p;
  logic [LOG_FRAC-1:0] lg_f;
  sb_t                 lg_sb;

  rrg_log u_log (
    .clk(clk), .rst(rst), .en(en), .in_valid(t1_v),
    .in_sb('{t: t1, neg: 1'b0}),
    .out_valid(lg_v), .int_part(lg_p), .frac_part(lg_f), .out_sb(lg_sb)
  );

  // Log minus the fraction offset, then divided by gamma.
  logic signed [35:0] lval;
  logic [34:0]        lmag;
  logic               l_v;
  logic [NUM_W-1:0]   l_num;
  logic [DEN_W-1:0]   l_den;
  sb_t                l_sb;

  assign lval = $signed({1'b0, lg_p, lg_f}) - LOG_OFS;
  assign lmag = lval[35] ? 35'(-lval) : lval[34:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else if (en) begin
      l_v <= lg_v;
    end
    if (en) begin
      l_num <= {lmag, {FRAC_BITS{1'b0}}};
      l_den <= (cfg.gamma == '0) ? DEN_W'(1) : DEN_W'(cfg.gamma);
      l_sb  <= '{t: lg_sb.t, neg: lval[35]};
    end
  end

  logic          d2_v;
  logic [QB-1:0] d2_q;
  sb_t           d2_sb;

  rrg_div u_div_gamma (
    .clk(clk), .rst(rst), .en(en), .in_valid(l_v),
    .num(l_num), .den(l_den), .in_sb(l_sb),
    .out_valid(d2_v), .quo(d2_q), .out_sb(d2_sb)
  );

  // Split the exponent into integer and fraction parts.
  logic signed [QB:0]  yv;
  logic signed [6:0]   nv;
  logic signed [7:0]   kx;
  logic                e_v;
  logic [LOG_FRAC-1:0] e_f;
  logic [5:0]          e_k;
  logic                e_mx;
  logic                e_zr;
  sb_t                 e_sb;

  assign yv = d2_sb.neg ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
  assign nv = yv[QB:LOG_FRAC];
  assign kx = 8'(31 - FRAC_BITS) - {nv[6], nv};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d2_v;
    end
    if (en) begin
      e_f  <= yv[LOG_FRAC-1:0];
      e_k  <= kx[5:0];
      e_mx <= nv >= N_MAX;
      e_zr <= nv < N_ZERO;
      e_sb <= d2_sb;
    end
  end

  logic               x_v;
  logic signed [31:0] x_t;
  sb_t                x_sb;

  rrg_exp u_exp (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_v),
    .frac(e_f), .shift(e_k), .to_max(e_mx), .to_zero(e_zr), .in_sb(e_sb),
    .out_valid(x_v), .result(x_t), .out_sb(x_sb)
  );

  // Scale into the output range.
  logic               gskip;
  logic signed [31:0] tsel;
  logic signed [32:0] span;
  logic signed [64:0] prod;
  logic               p0_v;
  logic signed [64:0] p0_prod;

  assign gskip = cfg.gamma == GAMMA_ONE;
  assign span  = $signed({cfg.out_high[31], cfg.out_high})
               - $signed({cfg.out_low[31], cfg.out_low});
  assign prod  = tsel * span;

  always_comb begin
    if (gskip) begin
      tsel = x_sb.t;
    end else if (x_sb.t > 32'sd0) begin
      tsel = x_t;
    end else begin
      tsel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (en) begin
      p0_v <= x_v;
    end
    if (en) begin
      p0_prod <= prod;
    end
  end

  logic signed [65:0] osum;
  logic               p1_v;
  logic signed [31:0] p1_r;

  assign osum = $signed({p0_prod[64], p0_prod >>> FRAC_BITS})
              + 66'(cfg.out_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= p0_v;
    end
    if (en) begin
      if (osum > 66'sh0_7FFF_FFFF) begin
        p1_r <= 32'sh7FFF_FFFF;
      end else if (osum < -66'sh0_8000_0000) begin
        p1_r <= 32'sh8000_0000;
      end else begin
        p1_r <= osum[31:0];
      end
    end
  end

  // Degenerate input range and the optional clamp.
  logic signed [31:0] rsel;
  logic signed [31:0] rlo;
  logic               p2_v;
  logic signed [31:0] p2_r;

  assign rsel = (cfg.in_high == cfg.in_low) ? cfg.out_low : p1_r;
  assign rlo  = (rsel < cfg.out_low) ? cfg.out_low : rsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
    if (en) begin
      if (!cfg.clamp_enable) begin
        p2_r <= rsel;
      end else if (rlo > cfg.out_high) begin
        p2_r <= cfg.out_high;
      end else begin
        p2_r <= rlo;
      end
    end
  end

  assign out_valid = p2_v;
  assign result    = p2_r;

endmodule

// ===== design/range_remap_gamma_clamp_unit.sv =====
// Four-channel range remap with gamma curve and optional clamp.
// Items enter on in_item (valid/ready) carrying value_a..value_d in signed
// Q16.16 and leave on out_item carrying result_a..result_d. Each channel runs
// in its own lane: normalize by a pipelined divider, log2 by repeated
// squaring, divide by gamma, exp2 by a product of constants, then scale,
// saturate and clamp. Every lane step ends in a pipeline register stage.
// Settings are written through write_en/write_index/write_data while no item
// is in flight, a rule the user keeps as the block itself has no check for
// it; unknown indices are ignored. One item is accepted per cycle while
// in_item.ready is high, set by the fully pipelined lanes.
// Reset (rst, synchronous) empties the pipeline and loads the default
// settings: input and output range 0 to 1.0, gamma 1.0, clamp off.
// When the receiver stalls, a held result waits in the output register and
// one more item is caught in a skid register; then in_item.ready drops and
// the whole pipeline holds until the receiver takes the waiting item.
module range_remap_gamma_clamp_unit (
  input  logic                               clk,
  input  logic                               rst,
  rrg_in_if.sink                             in_item,
  rrg_out_if.source                          out_item,
  input  logic                               write_en,
  input  logic [rrg_pkg::CFG_IDX_W-1:0]      write_index,
  input  logic [rrg_pkg::CFG_DATA_W-1:0]     write_data
);
  import rrg_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_low       <= '0;
      cfg.in_high      <= 32'sd1 <<< FRAC_BITS;
      cfg.gamma        <= GAMMA_ONE;
      cfg.out_low      <= '0;
      cfg.out_high     <= 32'sd1 <<< FRAC_BITS;
      cfg.clamp_enable <= 1'b0;
    end else if (write_en) begin
      case (write_index)
        REG_IN_LOW:       cfg.in_low       <= $signed(write_data);
        REG_IN_HIGH:      cfg.in_high      <= $signed(write_data);
        REG_GAMMA:        cfg.gamma        <= write_data[30:0];
        REG_OUT_LOW:      cfg.out_low      <= $signed(write_data);
        REG_OUT_HIGH:     cfg.out_high     <= $signed(write_data);
        REG_CLAMP_ENABLE: cfg.clamp_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  logic               en;
  logic               sval;
  logic               oval;
  logic               take;
  logic [LANES-1:0]   lane_v;
  logic signed [31:0] vin  [0:NUM_FIELDS-1];
  logic signed [31:0] lres [0:NUM_FIELDS-1];
  logic signed [31:0] odat [0:NUM_FIELDS-1];
  logic signed [31:0] sdat [0:NUM_FIELDS-1];

  assign en   = !sval;
  assign take = oval && out_item.ready;

  assign vin[0] = in_item.value_a;
  assign vin[1] = in_item.value_b;
  assign vin[2] = in_item.value_c;
  assign vin[3] = in_item.value_d;

  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
    if (i < LANES) begin : g_on
      rrg_lane u_lane (
        .clk(clk), .rst(rst), .en(en), .cfg(cfg),
        .in_valid(in_item.valid && in_item.ready), .value(vin[i]),
        .out_valid(lane_v[i]), .result(lres[i])
      );
    end else begin : g_off
      assign lres[i] = '0;
    end
  end

  // Output register with a one-item skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
      sval <= 1'b0;
    end else if (sval) begin
      if (take) begin
        sval <= 1'b0;
      end
    end else if (!oval || take) begin
      oval <= lane_v[0];
    end else if (lane_v[0]) begin
      sval <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sval) begin
      if (take) begin
        odat <= sdat;
      end
    end else if (!oval || take) begin
      odat <= lres;
    end else if (lane_v[0]) begin
      sdat <= lres;
    end
  end

  assign in_item.ready     = !sval;
  assign out_item.valid    = oval;
  assign out_item.result_a = odat[0];
  assign out_item.result_b = odat[1];
  assign out_item.result_c = odat[2];
  assign out_item.result_d = odat[3];

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sval |-> oval)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sval) |-> $past(oval && !out_item.ready && lane_v[0]))
    else $error("skid register filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (sval && out_item.ready) |=> !sval)
    else $error("skid register not drained after the output was taken");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (lane_v == '0) || (lane_v == '1))
    else $error("lanes disagree on item position");
`endif

endmodule

// ===== dv/range_remap_gamma_clamp_unit_tb.sv =====
module range_remap_gamma_clamp_unit_tb;
  import rrg_pkg::*;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } pixel_t;

  logic clk;
  logic rst;
  logic write_en;
  logic [CFG_IDX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0] write_data;

  rrg_in_if in_item ();
  rrg_out_if out_item ();

  range_remap_gamma_clamp_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_item(in_item.sink),
    .out_item(out_item.source),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data)
  );

  cfg_t model_cfg;
  logic [63:0] root_coef [1:LOG_FRAC];
  pixel_t pending_pixels[$];
  int errors;
  bit send_steady;
  bit recv_steady;
  bit hold_request;
  int hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bv;
    res = '0;
    bv = 64'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Log2 in Q.30: integer part from the leading one, fraction by squaring.
  function automatic longint log2_fixed(logic [31:0] x);
    int p;
    logic [63:0] m;
    longint r;
    p = 31;
    while (p > 0 && x[p] == 1'b0) p--;
    m = 64'(x) << (31 - p);
    r = longint'(p) <<< LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        r = r + (longint'(1) <<< i);
      end
    end
    return r;
  endfunction

  function automatic longint gamma_curve(longint t, longint g);
    longint l;
    longint y;
    longint n;
    longint k;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] r;
    l = log2_fixed(t[31:0]) - (longint'(FRAC_BITS) <<< LOG_FRAC);
    y = (l * (longint'(1) <<< FRAC_BITS)) / g;
    n = y >>> LOG_FRAC;
    f = 64'(y - n * (longint'(1) <<< LOG_FRAC));
    if (n >= 31 - FRAC_BITS) return 64'sd2147483647;
    k = 31 - n - FRAC_BITS;
    if (k > 40) return 0;
    acc = 64'd1 << 31;
    for (int b = 1; b <= LOG_FRAC; b++)
      if (f[LOG_FRAC - b]) acc = (acc * root_coef[b]) >> 31;
    r = (acc + (64'd1 << (k - 1))) >> k;
    return clip32(longint'(r));
  endfunction

  function automatic logic signed [31:0] remap_channel(logic signed [31:0] v);
    longint lo;
    longint hi;
    longint olo;
    longint ohi;
    longint t;
    longint g;
    longint r;
    lo = model_cfg.in_low;
    hi = model_cfg.in_high;
    olo = model_cfg.out_low;
    ohi = model_cfg.out_high;
    if (hi == lo) begin
      r = olo;
    end else begin
      t = clip32(((longint'(v) - lo) * (longint'(1) <<< FRAC_BITS)) / (hi - lo));
      g = (model_cfg.gamma == 0) ? 1 : longint'(model_cfg.gamma);
      if (g != (longint'(1) <<< FRAC_BITS)) t = (t > 0) ? gamma_curve(t, g) : 0;
      r = clip32(((t * (ohi - olo)) >>> FRAC_BITS) + olo);
    end
    if (model_cfg.clamp_enable) begin
      if (r < olo) r = olo;
      if (r > ohi) r = ohi;
    end
    return r[31:0];
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    errors++;
  endtask

  // Result checker: every accepted item is compared with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_item.valid && out_item.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("unexpected result item at %0t", $time);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.result_a !== want.a) report_mismatch("result_a", out_item.result_a, want.a);
        if (out_item.result_b !== want.b) report_mismatch("result_b", out_item.result_b, want.b);
        if (out_item.result_c !== want.c) report_mismatch("result_c", out_item.result_c, want.c);
        if (out_item.result_d !== want.d) report_mismatch("result_d", out_item.result_d, want.d);
      end
    end
  end

  // Receiver: random stalls, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) hold_left--;
    if (rst || hold_left > 0) out_item.ready <= 1'b0;
    else if (recv_steady) out_item.ready <= 1'b1;
    else out_item.ready <= ($urandom_range(99) >= 9);
  end

  task automatic send_pixel(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c, logic signed [31:0] d);
    pixel_t want;
    if (!send_steady && $urandom_range(99) < 9) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.value_a <= a;
    in_item.value_b <= b;
    in_item.value_c <= c;
    in_item.value_d <= d;
    do @(posedge clk); while (!in_item.ready);
    want.a = remap_channel(a);
    want.b = remap_channel(b);
    want.c = remap_channel(c);
    want.d = remap_channel(d);
    pending_pixels.push_back(want);
  endtask

  task automatic drain_pipeline();
    in_item.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // Writes all six registers, then two indices that must be ignored.
  task automatic load_settings(logic [31:0] lo, logic [31:0] hi, logic [31:0] g,
                               logic [31:0] olo, logic [31:0] ohi, logic clamp);
    logic [31:0] vals [6];
    logic [CFG_IDX_W-1:0] idx [6];
    vals = '{lo, hi, g, olo, ohi, 32'(clamp)};
    idx = '{REG_IN_LOW, REG_IN_HIGH, REG_GAMMA, REG_OUT_LOW, REG_OUT_HIGH, REG_CLAMP_ENABLE};
    for (int i = 0; i < 6; i++) begin
      write_en <= 1'b1;
      write_index <= idx[i];
      write_data <= vals[i];
      @(posedge clk);
    end
    for (int i = 6; i < 8; i++) begin
      write_en <= 1'b1;
      write_index <= CFG_IDX_W'(i);
      write_data <= $urandom;
      @(posedge clk);
    end
    write_en <= 1'b0;
    model_cfg.in_low = lo;
    model_cfg.in_high = hi;
    model_cfg.gamma = g[30:0];
    model_cfg.out_low = olo;
    model_cfg.out_high = ohi;
    model_cfg.clamp_enable = clamp;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      default: return 32'($signed($urandom_range(0, 32'h30000)) - 32'sh8000);
    endcase
  endfunction

  task automatic test_defaults();
    send_pixel(0, 32'h10000, 32'h8000, -32'sh8000);
    send_pixel(32'h8000_0000, 32'h7fff_ffff, 1, -1);
    send_pixel(32'h20000, 32'h4000, 32'hc000, 32'hffff);
    drain_pipeline();
  endtask

  task automatic test_gamma_curve();
    load_settings(0, 32'h10000, 32'h20000, 0, 32'h10000, 1'b0);
    send_pixel(32'h4000, 32'h10000, 0, -32'sh100);
    send_pixel(1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000);
    drain_pipeline();
    // Zero gamma behaves as the smallest gamma; t above 1.0 then saturates.
    load_settings(0, 32'h10000, 0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_pixel(32'h10000, 32'h8000, 32'h20000, 1);
    drain_pipeline();
    load_settings(0, 32'h10000, 32'h7fff_ffff, 0, 32'h10000, 1'b0);
    send_pixel(1, 32'h8000, 32'h7fff_ffff, 32'h100);
    drain_pipeline();
    load_settings(32'h8000_0000, 32'h7fff_ffff, 1, 0, 32'h10000, 1'b0);
    send_pixel(0, 32'h7fff_ffff, 32'h8000_0000, 1);
    drain_pipeline();
  endtask

  task automatic test_edge_settings();
    // Equal input bounds give out_low.
    load_settings(32'h5000, 32'h5000, 32'h10000, 32'h3000, 32'h9000, 1'b0);
    send_pixel(0, 32'h7fff_ffff, 32'h8000_0000, 32'h5000);
    drain_pipeline();
    // Inverted output bounds with clamping give out_high.
    load_settings(0, 32'h10000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
    send_pixel(0, 32'h8000, 32'h10000, -32'sh10000);
    drain_pipeline();
    load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h10000,
                  32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_pixel(32'h8000_0000, 32'h7fff_ffff, 0, -1);
    drain_pipeline();
    load_settings(32'h10000, 0, 32'h18000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_pixel(32'h8000, 32'h20000, -32'sh10000, 32'h7fff_ffff);
    drain_pipeline();
  endtask

  task automatic test_random_settings();
    logic [31:0] lo;
    logic [31:0] g;
    for (int phase = 0; phase < 12; phase++) begin
      lo = pick_value();
      case ($urandom_range(3))
        0: g = 32'h10000;
        1: g = $urandom;
        2: g = $urandom_range(1, 16);
        default: g = $urandom_range(32'h2000, 32'h80000);
      endcase
      load_settings(lo, ($urandom_range(7) == 0) ? lo : pick_value(), g,
                    pick_value(), pick_value(), $urandom_range(1));
      send_steady = (phase == 5);
      recv_steady = (phase == 5);
      repeat (100) send_pixel(pick_value(), pick_value(), pick_value(), pick_value());
      drain_pipeline();
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    load_settings(0, 32'h10000, 32'h28000, 32'hffff_0000, 32'h30000, 1'b1);
    send_steady = 1'b1;
    hold_request = 1'b1;
    repeat (400) send_pixel(pick_value(), pick_value(), pick_value(), pick_value());
    send_steady = 1'b0;
    drain_pipeline();
  endtask

  initial begin
    logic [63:0] c;
    clk = 1'b0;
    rst = 1'b1;
    write_en = 1'b0;
    write_index = '0;
    write_data = '0;
    in_item.valid = 1'b0;
    in_item.value_a = '0;
    in_item.value_b = '0;
    in_item.value_c = '0;
    in_item.value_d = '0;
    out_item.ready = 1'b0;
    errors = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    c = 64'd1 << 32;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      c = int_sqrt(c << 31);
      root_coef[k] = c;
    end
    model_cfg.in_low = 0;
    model_cfg.in_high = 32'h10000;
    model_cfg.gamma = GAMMA_ONE;
    model_cfg.out_low = 0;
    model_cfg.out_high = 32'h10000;
    model_cfg.clamp_enable = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_gamma_curve();
    test_edge_settings();
    test_random_settings();
    test_backpressure();
    if (errors == 0) begin
      $display("range_remap_gamma_clamp_unit_tb: PASS");
    end else begin
      $display("range_remap_gamma_clamp_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("range_remap_gamma_clamp_unit_tb: FAIL");
    $finish;
  end

endmodule
